// ===== rtl/amo_pkg.sv =====
// package: types, codes and fault selection shared by the atomic memory op unit
`timescale 1ns / 1ps
`default_nettype none

package amo_pkg;

  // stream payload widths; both tdata widths padded to whole bytes
  localparam int unsigned InTdataW  = 264;
  localparam int unsigned InTuserW  = 4;
  localparam int unsigned OutTdataW = 136;

  // operation codes
  typedef enum logic [3:0] {
    OP_LR    = 4'd0,
    OP_SC    = 4'd1,
    OP_SWAP  = 4'd2,
    OP_ADD   = 4'd3,
    OP_XOR   = 4'd4,
    OP_AND   = 4'd5,
    OP_OR    = 4'd6,
    OP_MIN   = 4'd7,
    OP_MAX   = 4'd8,
    OP_MINU  = 4'd9,
    OP_MAXU  = 4'd10,
    OP_CAS   = 4'd11,
    OP_SNOOP = 4'd12
  } amo_op_e;

  // fault codes
  typedef enum logic [2:0] {
    FLT_NONE       = 3'd0,
    FLT_LD_MISAL   = 3'd1,
    FLT_LD_ACCESS  = 3'd2,
    FLT_ST_MISAL   = 3'd3,
    FLT_ST_ACCESS  = 3'd4
  } amo_fault_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_MISAL_AS_ACC = 2'd0,
    CFG_MISAL_PRIO   = 2'd1,
    CFG_RES_LOG2     = 2'd2,
    CFG_KEEP_RES     = 2'd3
  } amo_cfg_idx_e;

  localparam logic [3:0] ResLog2Reset = 4'd3;
  localparam logic [3:0] WordLog2     = 4'd2;
  localparam logic [3:0] DwordLog2    = 4'd3;

  typedef struct packed {
    logic       misal_as_acc;
    logic       misal_prio;
    logic [3:0] res_log2;
    logic       keep_res;
  } amo_cfg_t;

  typedef struct packed {
    logic [3:0]  op;
    logic        is_double;
    logic [63:0] address;
    logic [63:0] memory_value;
    logic [63:0] source_value;
    logic [63:0] compare_value;
    logic        access_fault;
  } amo_item_t;

  typedef struct packed {
    logic [63:0] rd_value;
    logic        rd_write;
    logic [63:0] store_value;
    logic        store_enable;
    amo_fault_e  fault;
  } amo_res_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] address;
    logic [3:0]  bytes_log2;
  } amo_resv_t;

  // misalignment may win over access fault, and may be reported as one
  function automatic amo_fault_e pick_fault(input logic misal, input logic acc,
                                            input logic is_load, input amo_cfg_t cfg);
    amo_fault_e mis_code;
    amo_fault_e acc_code;
    amo_fault_e m_code;
    amo_fault_e res;
    mis_code = is_load ? FLT_LD_MISAL : FLT_ST_MISAL;
    acc_code = is_load ? FLT_LD_ACCESS : FLT_ST_ACCESS;
    m_code   = cfg.misal_as_acc ? acc_code : mis_code;
    if (misal && cfg.misal_prio) begin
      res = m_code;
    end else if (acc) begin
      res = acc_code;
    end else if (misal) begin
      res = m_code;
    end else begin
      res = FLT_NONE;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/atomic_memory_op_unit_top.sv =====
// top level: stream wrapper, configuration and reservation registers of the atomic unit
// an accepted item passes the input register, then the result register, before its result is offered
// one item per cycle unless the output stalls; the reservation is updated as each item leaves the input register
// a stalled result register holds the input register, so the input stalls once both are full
// reset clears both valid flags, the reservation and sets the configuration to its defaults
`timescale 1ns / 1ps
`default_nettype none

module atomic_memory_op_unit_top
  import amo_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration write port
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_index_i,
  input  wire logic [3:0]           cfg_wdata_i,
  // input stream
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // is_double, address, memory_value, source_value, compare_value, access_fault
  input  wire logic [InTdataW-1:0]  s_axis_tdata,
  // operation
  input  wire logic [InTuserW-1:0]  s_axis_tuser,
  // result stream
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // rd_value, rd_write, store_value, store_enable, fault
  output logic [OutTdataW-1:0]      m_axis_tdata
);

  amo_cfg_t  cfg_q;
  amo_item_t item_q;
  logic      in_valid_q;
  amo_res_t  res_d;
  amo_res_t  res_q;
  logic      out_valid_q;
  amo_resv_t resv_d;
  amo_resv_t resv_q;
  logic      s_accept;
  logic      advance;

  // handshake
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.misal_as_acc <= 1'b0;
      cfg_q.misal_prio   <= 1'b0;
      cfg_q.res_log2     <= ResLog2Reset;
      cfg_q.keep_res     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MISAL_AS_ACC: cfg_q.misal_as_acc <= cfg_wdata_i[0];
        CFG_MISAL_PRIO:   cfg_q.misal_prio   <= cfg_wdata_i[0];
        CFG_RES_LOG2:     cfg_q.res_log2     <= cfg_wdata_i;
        CFG_KEEP_RES:     cfg_q.keep_res     <= cfg_wdata_i[0];
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      item_q.op            <= s_axis_tuser;
      item_q.is_double     <= s_axis_tdata[0];
      item_q.address       <= s_axis_tdata[64:1];
      item_q.memory_value  <= s_axis_tdata[128:65];
      item_q.source_value  <= s_axis_tdata[192:129];
      item_q.compare_value <= s_axis_tdata[256:193];
      item_q.access_fault  <= s_axis_tdata[257];
    end
  end

  // execute
  amo_exec u_exec (
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .resv_i (resv_q),
    .res_o  (res_d),
    .resv_o (resv_d)
  );

  // reservation register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resv_q <= '0;
    end else if (advance) begin
      resv_q <= resv_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'd0, res_q.fault, res_q.store_enable, res_q.store_value,
                          res_q.rd_write, res_q.rd_value};

`ifndef SYNTH
  // a faulting atomic writes neither rd nor memory
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.fault != FLT_NONE) |-> (!res_q.rd_write && !res_q.store_enable))
    else $error("faulting result writes rd or memory");

  // a clean lr leaves a valid reservation behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && item_q.op == OP_LR && res_d.fault == FLT_NONE) |=> resv_q.valid)
    else $error("lr did not set the reservation");

  // a valid reservation spans at least one word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    resv_q.valid |-> (resv_q.bytes_log2 >= WordLog2))
    else $error("reservation granule below word size");

  // a store-conditional never leaves the reservation set unless it faulted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && item_q.op == OP_SC && res_d.fault == FLT_NONE) |=> !resv_q.valid)
    else $error("clean sc kept the reservation");
`endif

endmodule

`default_nettype wire

// ===== rtl/amo_exec.sv =====
// execute logic: one atomic against the reservation, gives result and next reservation
`timescale 1ns / 1ps
`default_nettype none

module amo_exec
  import amo_pkg::*;
(
  input  amo_item_t item_i,
  input  amo_cfg_t  cfg_i,
  input  amo_resv_t resv_i,
  output amo_res_t  res_o,
  output amo_resv_t resv_o
);

  logic [63:0] dmask;
  logic [63:0] mem;
  logic [63:0] src;
  logic [63:0] cmp;
  logic [63:0] old;
  logic [63:0] sa;
  logic [63:0] r;
  logic [63:0] diff;
  logic [63:0] rdiff;
  logic [63:0] gmask;
  logic [15:0] rsize;
  logic [15:0] room;
  logic [3:0]  size;
  logic [3:0]  slog;
  logic [3:0]  g;
  logic        misal;
  logic        st;
  logic        sc_ok;
  logic        snoop_hit;
  amo_fault_e  flt_ld;
  amo_fault_e  flt_st;

  // operand shaping: word data from the low half
  always_comb begin
    dmask = item_i.is_double ? '1 : {32'd0, 32'hFFFF_FFFF};
    mem   = item_i.memory_value & dmask;
    src   = item_i.source_value & dmask;
    cmp   = item_i.compare_value & dmask;
    old   = item_i.is_double ? mem : {{32{mem[31]}}, mem[31:0]};
    sa    = item_i.is_double ? src : {{32{src[31]}}, src[31:0]};
    size  = item_i.is_double ? 4'd8 : 4'd4;
    slog  = item_i.is_double ? DwordLog2 : WordLog2;
    misal = item_i.is_double ? (item_i.address[2:0] != 3'd0)
                             : (item_i.address[1:0] != 2'd0);
    flt_ld = pick_fault(misal, item_i.access_fault, 1'b1, cfg_i);
    flt_st = pick_fault(misal, item_i.access_fault, 1'b0, cfg_i);
  end

  // reservation geometry checks
  always_comb begin
    g         = (cfg_i.res_log2 > slog) ? cfg_i.res_log2 : slog;
    gmask     = ~((64'd1 << g) - 64'd1);
    rsize     = 16'd1 << resv_i.bytes_log2;
    room      = rsize - {12'd0, size};
    diff      = item_i.address - resv_i.address;
    rdiff     = resv_i.address - item_i.address;
    sc_ok     = resv_i.valid && (rsize >= {12'd0, size}) && (diff <= {48'd0, room});
    snoop_hit = resv_i.valid && ((diff < {48'd0, rsize}) || (rdiff < {60'd0, size}));
  end

  // read-modify-write value
  always_comb begin
    st = 1'b1;
    r  = src;
    case (item_i.op)
      OP_ADD:  r = src + mem;
      OP_XOR:  r = src ^ mem;
      OP_AND:  r = src & mem;
      OP_OR:   r = src | mem;
      OP_MIN:  r = ($signed(sa) < $signed(old)) ? src : mem;
      OP_MAX:  r = ($signed(sa) < $signed(old)) ? mem : src;
      OP_MINU: r = (src < mem) ? src : mem;
      OP_MAXU: r = (src < mem) ? mem : src;
      OP_CAS:  st = (mem == cmp);
      default: r = src;
    endcase
  end

  // per-operation result and reservation update
  always_comb begin
    res_o  = '0;
    resv_o = resv_i;
    unique case (item_i.op)
      OP_LR: begin
        res_o.fault = flt_ld;
        if (flt_ld == FLT_NONE) begin
          res_o.rd_value    = old;
          res_o.rd_write    = 1'b1;
          resv_o.valid      = 1'b1;
          resv_o.bytes_log2 = g;
          resv_o.address    = item_i.address & gmask;
        end
      end
      OP_SC: begin
        res_o.fault = flt_st;
        if (flt_st == FLT_NONE) begin
          res_o.rd_write = 1'b1;
          if (sc_ok) begin
            res_o.store_value  = src;
            res_o.store_enable = 1'b1;
          end else begin
            res_o.rd_value = 64'd1;
          end
        end
        if (flt_st == FLT_NONE || !cfg_i.keep_res) begin
          resv_o.valid = 1'b0;
        end
      end
      OP_SNOOP: begin
        if (snoop_hit) begin
          resv_o.valid = 1'b0;
        end
      end
      OP_SWAP, OP_ADD, OP_XOR, OP_AND, OP_OR, OP_MIN, OP_MAX, OP_MINU, OP_MAXU,
      OP_CAS: begin
        res_o.fault = flt_st;
        if (flt_st == FLT_NONE) begin
          res_o.rd_value = old;
          res_o.rd_write = 1'b1;
          if (st) begin
            res_o.store_value  = r & dmask;
            res_o.store_enable = 1'b1;
          end
        end
      end
      default: begin
        res_o  = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== bench/atomic_memory_op_unit_top_tb.sv =====
// testbench for the atomic memory op unit: stream driver, result monitor and predictor
`timescale 1ns / 1ps

module atomic_memory_op_unit_top_tb;
  import amo_pkg::*;

  // receiver stall patterns
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_HALF,
    RX_SPARSE,
    RX_TOGGLE
  } rx_pattern_e;

  localparam int unsigned FirstReservedOp = OP_SNOOP + 1;
  localparam int unsigned LastOpCode      = (1 << InTuserW) - 1;
  localparam int unsigned LongHoldCycles  = 300;
  localparam int unsigned HoldAfterResults = 100;
  localparam int unsigned RandomPhases    = 7;
  localparam int unsigned ItemsPerPhase   = 140;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                 cfg_we_i    = 1'b0;
  logic [1:0]           cfg_index_i = '0;
  logic [3:0]           cfg_wdata_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata  = '0;
  logic [InTuserW-1:0]  s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;

  atomic_memory_op_unit_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // shadow configuration and reservation
  logic        cfg_misal_acc  = 1'b0;
  logic        cfg_misal_prio = 1'b0;
  logic [3:0]  cfg_res_log2   = ResLog2Reset;
  logic        cfg_keep_res   = 1'b0;
  logic        resv_valid_q   = 1'b0;
  logic [63:0] resv_addr_q    = '0;
  logic [3:0]  resv_log2_q    = '0;

  amo_item_t atomics_to_send[$];
  amo_res_t  expected_amo_results[$];

  int unsigned errors     = 0;
  int unsigned n_accepted = 0;
  int unsigned n_checked  = 0;
  int unsigned n_sc_ok    = 0;
  int unsigned n_faulted  = 0;

  // fault code for one access under the current configuration
  function automatic amo_fault_e fault_for(input logic misal, input logic acc,
                                           input logic is_load);
    amo_fault_e acc_code;
    amo_fault_e mis_code;
    acc_code = is_load ? FLT_LD_ACCESS : FLT_ST_ACCESS;
    mis_code = cfg_misal_acc ? acc_code : (is_load ? FLT_LD_MISAL : FLT_ST_MISAL);
    if (misal && (cfg_misal_prio || !acc)) return mis_code;
    if (acc) return acc_code;
    return FLT_NONE;
  endfunction

  // expected result of one atomic, updating the shadow reservation
  function automatic amo_res_t amo_result_of(input amo_item_t it);
    amo_res_t    r;
    logic [63:0] dmask, mem, src, cmp, old, sa, nv, span, size;
    logic [3:0]  acc_log2, g;
    logic        misal, wr_mem, hit;
    r        = '0;
    dmask    = it.is_double ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
    mem      = it.memory_value & dmask;
    src      = it.source_value & dmask;
    cmp      = it.compare_value & dmask;
    size     = it.is_double ? 64'd8 : 64'd4;
    acc_log2 = it.is_double ? DwordLog2 : WordLog2;
    misal    = (it.address & (size - 64'd1)) != '0;
    old      = it.is_double ? mem : {{32{mem[31]}}, mem[31:0]};
    span     = 64'd1 << resv_log2_q;
    case (it.op)
      OP_LR: begin
        r.fault = fault_for(misal, it.access_fault, 1'b1);
        if (r.fault == FLT_NONE) begin
          g = (cfg_res_log2 > acc_log2) ? cfg_res_log2 : acc_log2;
          r.rd_value   = old;
          r.rd_write   = 1'b1;
          resv_valid_q = 1'b1;
          resv_log2_q  = g;
          resv_addr_q  = it.address & ~((64'd1 << g) - 64'd1);
        end
      end
      OP_SC: begin
        r.fault = fault_for(misal, it.access_fault, 1'b0);
        if (r.fault == FLT_NONE) begin
          hit = resv_valid_q && span >= size && (it.address - resv_addr_q) <= span - size;
          r.rd_write = 1'b1;
          if (hit) begin
            r.store_value  = src;
            r.store_enable = 1'b1;
          end else begin
            r.rd_value = 64'd1;
          end
        end
        if (r.fault == FLT_NONE || !cfg_keep_res) resv_valid_q = 1'b0;
      end
      OP_SNOOP: begin
        // a store touching any byte of the granule kills the reservation
        if (resv_valid_q && ((it.address - resv_addr_q) < span ||
                             (resv_addr_q - it.address) < size))
          resv_valid_q = 1'b0;
      end
      OP_SWAP, OP_ADD, OP_XOR, OP_AND, OP_OR, OP_MIN, OP_MAX, OP_MINU, OP_MAXU,
      OP_CAS: begin
        r.fault = fault_for(misal, it.access_fault, 1'b0);
        if (r.fault == FLT_NONE) begin
          sa     = it.is_double ? src : {{32{src[31]}}, src[31:0]};
          wr_mem = 1'b1;
          case (it.op)
            OP_SWAP: nv = src;
            OP_ADD:  nv = src + mem;
            OP_XOR:  nv = src ^ mem;
            OP_AND:  nv = src & mem;
            OP_OR:   nv = src | mem;
            OP_MIN:  nv = ($signed(sa) < $signed(old)) ? src : mem;
            OP_MAX:  nv = ($signed(sa) < $signed(old)) ? mem : src;
            OP_MINU: nv = (src < mem) ? src : mem;
            OP_MAXU: nv = (src < mem) ? mem : src;
            default: begin
              wr_mem = (mem == cmp);
              nv     = src;
            end
          endcase
          r.rd_value = old;
          r.rd_write = 1'b1;
          if (wr_mem) begin
            r.store_value  = nv & dmask;
            r.store_enable = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // sender: bursts of random length with random gaps
  amo_item_t   drv_item;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      burst_left    <= 0;
      gap_left      <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left != 0) begin
        gap_left      <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (atomics_to_send.size() != 0) begin
        drv_item      = atomics_to_send.pop_front();
        s_axis_tdata  <= {6'd0, drv_item.access_fault, drv_item.compare_value,
                          drv_item.source_value, drv_item.memory_value,
                          drv_item.address, drv_item.is_double};
        s_axis_tuser  <= drv_item.op;
        s_axis_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: changing stall pattern plus one long hold-off
  rx_pattern_e rx_pattern = RX_ALWAYS;
  int unsigned rx_cycle   = 0;
  int unsigned hold_left  = 0;
  logic        hold_done  = 1'b0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 64 == 0) rx_pattern <= rx_pattern_e'($urandom_range(0, 3));
      if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && n_checked >= HoldAfterResults) begin
        hold_done     <= 1'b1;
        hold_left     <= LongHoldCycles;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_pattern)
          RX_ALWAYS: m_axis_tready <= 1'b1;
          RX_HALF:   m_axis_tready <= ($urandom_range(0, 1) != 0);
          RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default:   m_axis_tready <= rx_cycle[0];
        endcase
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // monitor: check each result item, then predict each accepted input item
  amo_res_t  want_res;
  amo_item_t seen_item;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_amo_results.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected result item, expected none, actual %h",
                   $time, m_axis_tdata);
        end else begin
          want_res = expected_amo_results.pop_front();
          check_field("rd_value", want_res.rd_value, m_axis_tdata[63:0]);
          check_field("rd_write", want_res.rd_write, m_axis_tdata[64]);
          check_field("store_value", want_res.store_value, m_axis_tdata[128:65]);
          check_field("store_enable", want_res.store_enable, m_axis_tdata[129]);
          check_field("fault", want_res.fault, m_axis_tdata[132:130]);
        end
        n_checked <= n_checked + 1;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        seen_item.op            = s_axis_tuser;
        seen_item.is_double     = s_axis_tdata[0];
        seen_item.address       = s_axis_tdata[64:1];
        seen_item.memory_value  = s_axis_tdata[128:65];
        seen_item.source_value  = s_axis_tdata[192:129];
        seen_item.compare_value = s_axis_tdata[256:193];
        seen_item.access_fault  = s_axis_tdata[257];
        want_res = amo_result_of(seen_item);
        expected_amo_results.push_back(want_res);
        n_accepted++;
        if (want_res.fault != FLT_NONE) n_faulted++;
        if (seen_item.op == OP_SC && want_res.store_enable) n_sc_ok++;
      end
    end
  end

  // stimulus helpers
  function automatic logic [63:0] rand_data();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 64'hFFFF_FFFF_FFFF_FFFF;
      2:       return {$urandom, 32'h8000_0000};
      3:       return {32'h8000_0000, $urandom};
      4:       return {$urandom, 32'h7FFF_FFFF};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [63:0] new_anchor();
    case ($urandom_range(0, 3))
      0:       return {32'd0, $urandom_range(0, 32'hFFFF) << 4};
      1:       return 64'hFFFF_FFFF_FFFF_F000 + ($urandom_range(0, 255) << 4);
      2:       return {$urandom, $urandom} & ~64'h7;
      default: return 64'h0000_0000_8000_0000 + ($urandom_range(0, 4095) << 3);
    endcase
  endfunction

  // address around an anchor, usually aligned to the access size
  function automatic logic [63:0] near(input logic [63:0] anchor, input logic dbl,
                                       input int unsigned reach);
    logic [63:0] a;
    a = anchor + $urandom_range(0, reach) - 16;
    if ($urandom_range(0, 9) != 0) a = dbl ? a & ~64'h7 : a & ~64'h3;
    return a;
  endfunction

  task automatic send(input logic [3:0] op, input logic dbl, input logic [63:0] addr,
                      input logic [63:0] mem, input logic [63:0] src,
                      input logic [63:0] cmp, input logic acc);
    amo_item_t it;
    it.op            = op;
    it.is_double     = dbl;
    it.address       = addr;
    it.memory_value  = mem;
    it.source_value  = src;
    it.compare_value = cmp;
    it.access_fault  = acc;
    atomics_to_send.push_back(it);
  endtask

  task automatic send_random(input logic [3:0] op, input logic dbl,
                             input logic [63:0] addr, input int unsigned acc_odds);
    logic [63:0] mem;
    mem = rand_data();
    send(op, dbl, addr, mem, rand_data(), ($urandom_range(0, 1) != 0) ? mem : rand_data(),
         $urandom_range(0, acc_odds - 1) == 0);
  endtask

  task automatic queue_directed();
    int unsigned c;
    send(OP_SC,   1'b0, 64'h100, 64'h1234, 64'h55, 64'h0, 1'b0);   // no reservation
    send(OP_LR,   1'b1, 64'h100, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'h0, 1'b0);
    send(OP_SC,   1'b1, 64'h100, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0);
    send(OP_LR,   1'b0, 64'h204, 64'h8000_0000, 64'h0, 64'h0, 1'b0);
    send(OP_SNOOP, 1'b1, 64'h200, 64'h0, 64'h0, 64'h0, 1'b0);      // overlapping store
    send(OP_SC,   1'b0, 64'h204, 64'h0, 64'h77, 64'h0, 1'b0);
    send(OP_LR,   1'b0, 64'h103, 64'h1, 64'h0, 64'h0, 1'b1);        // misaligned and denied
    send(OP_SC,   1'b0, 64'h102, 64'h1, 64'h2, 64'h0, 1'b0);
    send(OP_SWAP, 1'b1, 64'h0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0);
    send(OP_ADD,  1'b0, 64'h8, 64'hFFFF_FFFF, 64'h1, 64'h0, 1'b0);
    send(OP_ADD,  1'b1, 64'h8, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1, 64'h0, 1'b0);
    send(OP_XOR,  1'b1, 64'h10, 64'hF0F0_F0F0_F0F0_F0F0, 64'hFFFF_0000_FFFF_0000, 64'h0, 1'b0);
    send(OP_AND,  1'b0, 64'h14, 64'hDEAD_BEEF_8765_4321, 64'hFFFF_0000_F0F0_FFFF, 64'h0, 1'b0);
    send(OP_OR,   1'b0, 64'h18, 64'h0, 64'hFFFF_FFFF_8000_0000, 64'h0, 1'b0);
    send(OP_MIN,  1'b0, 64'h1C, 64'h8000_0000, 64'h7FFF_FFFF, 64'h0, 1'b0);
    send(OP_MAX,  1'b0, 64'h1C, 64'h8000_0000, 64'h7FFF_FFFF, 64'h0, 1'b0);
    send(OP_MINU, 1'b1, 64'h20, 64'h8000_0000_0000_0000, 64'h1, 64'h0, 1'b0);
    send(OP_MAXU, 1'b1, 64'h20, 64'h8000_0000_0000_0000, 64'h1, 64'h0, 1'b0);
    send(OP_CAS,  1'b1, 64'h28, 64'h1122_3344_5566_7788, 64'h99, 64'h1122_3344_5566_7788, 1'b0);
    send(OP_CAS,  1'b0, 64'h2C, 64'hAAAA_0000_1234_5678, 64'h99, 64'hBBBB_0000_1234_5678, 1'b0);
    send(OP_CAS,  1'b1, 64'h30, 64'h5, 64'h99, 64'h6, 1'b0);
    send(OP_AND,  1'b1, 64'hFFFF_FFFF_FFFF_FFF8, 64'h1, 64'h1, 64'h0, 1'b1);
    for (c = FirstReservedOp; c <= LastOpCode; c++)
      send(c[3:0], 1'b1, {$urandom, $urandom}, rand_data(), rand_data(), rand_data(), 1'b0);
  endtask

  // mostly lr / other ops / sc runs around one granule, the rest loose items
  task automatic queue_random(input int unsigned n);
    int unsigned added, k, fill;
    logic [63:0] anchor;
    logic        dbl;
    logic [3:0]  op;
    added = 0;
    while (added < n) begin
      if ($urandom_range(0, 9) < 7) begin
        anchor = new_anchor();
        dbl    = 1'($urandom_range(0, 1));
        send_random(OP_LR, dbl, near(anchor, dbl, 16), 20);
        fill = $urandom_range(0, 3);
        for (k = 0; k < fill; k++) begin
          dbl = 1'($urandom_range(0, 1));
          op  = ($urandom_range(0, 2) == 0) ? OP_SNOOP : 4'($urandom_range(OP_SWAP, OP_CAS));
          send_random(op, dbl, near(anchor, dbl, ($urandom_range(0, 3) == 0) ? 8192 : 64), 12);
        end
        dbl = 1'($urandom_range(0, 1));
        send_random(OP_SC, dbl,
                    near(anchor, dbl, ($urandom_range(0, 3) == 0) ? 8192 : 40), 20);
        added += fill + 2;
      end else begin
        dbl = 1'($urandom_range(0, 1));
        send_random(4'($urandom_range(0, LastOpCode)), dbl,
                    ($urandom_range(0, 1) != 0) ? {$urandom, $urandom}
                                                : near(new_anchor(), dbl, 64), 6);
        added++;
      end
    end
  endtask

  // all four registers, back to back
  task automatic apply_config(input logic misal_acc, input logic misal_prio,
                              input logic [3:0] res_log2, input logic keep);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_MISAL_AS_ACC;
    cfg_wdata_i <= {3'd0, misal_acc};
    @(posedge clk_i);
    cfg_index_i <= CFG_MISAL_PRIO;
    cfg_wdata_i <= {3'd0, misal_prio};
    @(posedge clk_i);
    cfg_index_i <= CFG_RES_LOG2;
    cfg_wdata_i <= res_log2;
    @(posedge clk_i);
    cfg_index_i <= CFG_KEEP_RES;
    cfg_wdata_i <= {3'd0, keep};
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    cfg_misal_acc  = misal_acc;
    cfg_misal_prio = misal_prio;
    cfg_res_log2   = res_log2;
    cfg_keep_res   = keep;
  endtask

  task automatic configure_phase(input int unsigned ph);
    case (ph)
      0:       apply_config(1'b0, 1'b0, 4'd3, 1'b0);
      1:       apply_config(1'b1, 1'b0, 4'd2, 1'b0);
      2:       apply_config(1'b0, 1'b1, 4'd12, 1'b1);
      3:       apply_config(1'b1, 1'b1, 4'd2, 1'b1);
      4:       apply_config(1'b0, 1'b1, 4'd4, 1'b0);
      5:       apply_config(1'b1, 1'b0, 4'd12, 1'b1);
      default: apply_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            4'($urandom_range(2, 12)), 1'($urandom_range(0, 1)));
    endcase
  endtask

  // block is idle once nothing is queued, offered or outstanding
  task automatic wait_idle();
    while (atomics_to_send.size() != 0 || s_axis_tvalid || expected_amo_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // main sequence
  initial begin : main_seq
    int unsigned ph;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    queue_directed();
    wait_idle();
    for (ph = 0; ph < RandomPhases; ph++) begin
      configure_phase(ph);
      queue_random(ItemsPerPhase);
      wait_idle();
    end
    repeat (8) @(posedge clk_i);
    if (expected_amo_results.size() != 0) begin
      errors++;
      $display("%0t ns: results missing, expected %0d more, actual 0", $time,
               expected_amo_results.size());
    end
    $display("covered %0d atomics in %0d configurations, %0d results checked",
             n_accepted, RandomPhases + 1, n_checked);
    $display("  %0d store-conditionals succeeded, %0d items faulted", n_sc_ok, n_faulted);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/amo_pkg.sv
rtl/amo_exec.sv
rtl/atomic_memory_op_unit_top.sv
bench/atomic_memory_op_unit_top_tb.sv
